// ===== rtl/mandelbrot_escape_time_pixel_defines.svh =====
// Assertion macros shared by the escape-time pixel engine.
// Expects clk and rst_n in scope where used; no other dependencies.
`ifndef MANDELBROT_ESCAPE_TIME_PIXEL_DEFINES_SVH
`define MANDELBROT_ESCAPE_TIME_PIXEL_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define MBROT_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mbrot assertion failed");

// Next-cycle implication, checked outside reset
`define MBROT_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mbrot assertion failed");

`endif

// ===== rtl/mbrot_pkg.sv =====
// Types, constants and fixed-point helpers for the escape-time pixel engine.
// No dependencies; imported by every module of the block.
package mbrot_pkg;

    localparam int FRAC_BITS   = 26;
    localparam int COORD_BITS  = 12;
    localparam int Q_W         = FRAC_BITS + 6;
    localparam int W_W         = 2 * Q_W;
    localparam int ITER_W      = 25;
    localparam int STEP_W      = 28;
    localparam int CFG_W       = 28;
    localparam int CFG_IDX_W   = 2;
    localparam int IN_DATA_W   = 24;
    localparam int OUT_DATA_W  = 32;

    typedef logic signed [Q_W-1:0] q_t;
    typedef logic signed [W_W-1:0] wide_t;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_RE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_IM  = 2'd2;

    localparam logic [ITER_W-1:0] MAX_ITER_RST = 25'd524288;
    localparam logic [STEP_W-1:0] STEP_RE_RST  = 28'd251973;
    localparam logic [STEP_W-1:0] STEP_IM_RST  = 28'd252078;

    // Format limits and fixed-point constants
    localparam wide_t W_QMAX      = (wide_t'(1) <<< (Q_W - 1)) - wide_t'(1);
    localparam wide_t W_QMIN      = -(wide_t'(1) <<< (Q_W - 1));
    localparam wide_t W_ONE       = wide_t'(1) <<< FRAC_BITS;
    localparam wide_t W_QUARTER   = wide_t'(1) <<< (FRAC_BITS - 2);
    localparam wide_t W_HALF      = wide_t'(1) <<< (FRAC_BITS - 1);
    localparam wide_t W_M_3QTR    = -(wide_t'(3) <<< (FRAC_BITS - 2));
    localparam wide_t W_SIXTEENTH = wide_t'(1) <<< (FRAC_BITS - 4);
    localparam wide_t W_FOUR      = wide_t'(1) <<< (FRAC_BITS + 2);
    localparam wide_t W_RE_ORG    = wide_t'(2) <<< FRAC_BITS;
    localparam wide_t W_IM_ORG    = wide_t'(9) <<< (FRAC_BITS - 3);

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE, ST_CR, ST_CI, ST_RE2, ST_IM2, ST_RP1, ST_XX, ST_Q,
        ST_LHS, ST_CMP, ST_ZR2, ST_ZI2, ST_CROSS, ST_UPD, ST_OUT
    } state_t;

    // Operand pair fed to the shared multiplier
    typedef enum logic [3:0] {
        OP_NONE, OP_COL, OP_ROW, OP_CRCR, OP_CICI, OP_RP1, OP_XX,
        OP_QQX, OP_ZRZR, OP_ZIZI, OP_ZRZI
    } op_t;

    // Where the product registered last cycle goes
    typedef enum logic [3:0] {
        SNK_NONE, SNK_CR, SNK_CI, SNK_RE2, SNK_IM2, SNK_RP1, SNK_XX,
        SNK_LHS, SNK_ZR2, SNK_ZI2, SNK_CROSS
    } snk_t;

    typedef struct packed {
        logic ready;
        logic accept;
        op_t  op;
        snk_t snk;
        logic ld_out;
    } ctrl_t;

    typedef struct packed {
        logic interior;
        logic escape;
    } stat_t;

    function automatic wide_t wext(input q_t v);
        return wide_t'(v);
    endfunction

    // Clamp a wide value to the Q format range
    function automatic q_t sat_w(input wide_t v);
        q_t r;
        if (v > W_QMAX)
            r = q_t'(W_QMAX);
        else if (v < W_QMIN)
            r = q_t'(W_QMIN);
        else
            r = q_t'(v);
        return r;
    endfunction

    // Floor a raw product to FRAC_BITS fraction bits, then clamp
    function automatic q_t mulq(input wide_t p);
        return sat_w(p >>> FRAC_BITS);
    endfunction

endpackage

// ===== rtl/mbrot_mul.sv =====
// Shared signed multiplier with a registered full-width product.
// Depends on mbrot_pkg for the operand and product types.
module mbrot_mul
    import mbrot_pkg::*;
(
    input  logic  clk,
    input  q_t    a,
    input  q_t    b,
    output wide_t prod
);

    wide_t prod_reg;

    // Register the exact product every cycle
    always_ff @(posedge clk)
    begin
        prod_reg <= wext(a) * wext(b);
    end

    assign prod = prod_reg;

endmodule

// ===== rtl/mbrot_fsm.sv =====
// Sequencer of the pixel engine: schedules products on the shared multiplier.
// Depends on mbrot_pkg for state, control and status types.
module mbrot_fsm
    import mbrot_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  logic  out_free,
    input  stat_t stat,
    output ctrl_t ctrl
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (in_valid) state_next = ST_CR;
            ST_CR:    state_next = ST_CI;
            ST_CI:    state_next = ST_RE2;
            ST_RE2:   state_next = ST_IM2;
            ST_IM2:   state_next = ST_RP1;
            ST_RP1:   state_next = ST_XX;
            ST_XX:    state_next = ST_Q;
            ST_Q:     state_next = ST_LHS;
            ST_LHS:   state_next = ST_CMP;
            ST_CMP:   state_next = stat.interior ? ST_OUT : ST_ZR2;
            ST_ZR2:   state_next = ST_ZI2;
            ST_ZI2:   state_next = ST_CROSS;
            ST_CROSS: state_next = stat.escape ? ST_OUT : ST_UPD;
            ST_UPD:   state_next = ST_ZR2;
            ST_OUT:   if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Outputs: operand pair issued now, sink for last cycle's product
    always_comb
    begin
        ctrl        = '0;
        ctrl.op     = OP_NONE;
        ctrl.snk    = SNK_NONE;
        unique case (state_reg)
            ST_IDLE:
            begin
                ctrl.ready  = 1'b1;
                ctrl.accept = in_valid;
            end
            ST_CR:    ctrl.op = OP_COL;
            ST_CI:
            begin
                ctrl.op  = OP_ROW;
                ctrl.snk = SNK_CR;
            end
            ST_RE2:
            begin
                ctrl.op  = OP_CRCR;
                ctrl.snk = SNK_CI;
            end
            ST_IM2:
            begin
                ctrl.op  = OP_CICI;
                ctrl.snk = SNK_RE2;
            end
            ST_RP1:
            begin
                ctrl.op  = OP_RP1;
                ctrl.snk = SNK_IM2;
            end
            ST_XX:
            begin
                ctrl.op  = OP_XX;
                ctrl.snk = SNK_RP1;
            end
            ST_Q:     ctrl.snk = SNK_XX;
            ST_LHS:   ctrl.op = OP_QQX;
            ST_CMP:   ctrl.snk = SNK_LHS;
            ST_ZR2:   ctrl.op = OP_ZRZR;
            ST_ZI2:
            begin
                ctrl.op  = OP_ZIZI;
                ctrl.snk = SNK_ZR2;
            end
            ST_CROSS:
            begin
                ctrl.op  = OP_ZRZI;
                ctrl.snk = SNK_ZI2;
            end
            ST_UPD:   ctrl.snk = SNK_CROSS;
            ST_OUT:   ctrl.ld_out = out_free;
            default:  ctrl.ready = 1'b0;
        endcase
    end

endmodule

// ===== rtl/mbrot_dp.sv =====
// Datapath of the pixel engine: config registers, point and orbit registers,
// interior tests and escape test around the shared multiplier.
// Depends on mbrot_pkg and mbrot_mul.
module mbrot_dp
    import mbrot_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  ctrl_t                  ctrl,
    input  logic [COORD_BITS-1:0]  col,
    input  logic [COORD_BITS-1:0]  row,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]       cfg_data,
    output stat_t                  stat,
    output logic [ITER_W-1:0]      result
);

    logic [ITER_W-1:0]     max_iter_reg;
    logic [STEP_W-1:0]     step_re_reg;
    logic [STEP_W-1:0]     step_im_reg;
    logic [COORD_BITS-1:0] col_reg;
    logic [COORD_BITS-1:0] row_reg;
    q_t                    cr_reg;
    q_t                    ci_reg;
    q_t                    re2_reg;
    q_t                    im2_reg;
    q_t                    q_reg;
    q_t                    zr_reg;
    q_t                    zi_reg;
    q_t                    zr2_reg;
    q_t                    zi2_reg;
    logic                  disk_reg;
    logic                  inside_reg;
    logic [ITER_W-1:0]     n_reg;

    q_t    op_a;
    q_t    op_b;
    wide_t prod;
    q_t    mq;
    q_t    rp1;
    q_t    x;
    q_t    qx;
    logic  in_strip;
    logic  disk_hit;

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_iter_reg <= MAX_ITER_RST;
            step_re_reg  <= STEP_RE_RST;
            step_im_reg  <= STEP_IM_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MAX_ITER: max_iter_reg <= cfg_data[ITER_W-1:0];
                REG_STEP_RE:  step_re_reg  <= cfg_data[STEP_W-1:0];
                REG_STEP_IM:  step_im_reg  <= cfg_data[STEP_W-1:0];
                default:      max_iter_reg <= max_iter_reg;
            endcase
        end
    end

    // Derived operands
    assign mq       = mulq(prod);
    assign rp1      = sat_w(wext(cr_reg) + W_ONE);
    assign x        = sat_w(wext(cr_reg) - W_QUARTER);
    assign qx       = sat_w(wext(q_reg) + wext(x));
    assign in_strip = (wext(cr_reg) > W_M_3QTR) && (wext(cr_reg) < W_HALF);
    assign disk_hit = (wext(mq) + wext(im2_reg)) < W_SIXTEENTH;

    // Select the operand pair for the shared multiplier
    always_comb
    begin
        op_a = '0;
        op_b = '0;
        unique case (ctrl.op)
            OP_NONE:
            begin
                op_a = '0;
                op_b = '0;
            end
            OP_COL:
            begin
                op_a = q_t'({{(Q_W-COORD_BITS){1'b0}}, col_reg});
                op_b = q_t'({{(Q_W-STEP_W){1'b0}}, step_re_reg});
            end
            OP_ROW:
            begin
                op_a = q_t'({{(Q_W-COORD_BITS){1'b0}}, row_reg});
                op_b = q_t'({{(Q_W-STEP_W){1'b0}}, step_im_reg});
            end
            OP_CRCR:
            begin
                op_a = cr_reg;
                op_b = cr_reg;
            end
            OP_CICI:
            begin
                op_a = ci_reg;
                op_b = ci_reg;
            end
            OP_RP1:
            begin
                op_a = rp1;
                op_b = rp1;
            end
            OP_XX:
            begin
                op_a = x;
                op_b = x;
            end
            OP_QQX:
            begin
                op_a = q_reg;
                op_b = qx;
            end
            OP_ZRZR:
            begin
                op_a = zr_reg;
                op_b = zr_reg;
            end
            OP_ZIZI:
            begin
                op_a = zi_reg;
                op_b = zi_reg;
            end
            OP_ZRZI:
            begin
                op_a = zr_reg;
                op_b = zi_reg;
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    mbrot_mul u_mul (
        .clk  (clk),
        .a    (op_a),
        .b    (op_b),
        .prod (prod)
    );

    // Status for the sequencer
    assign stat.interior = disk_reg || (in_strip && (mq < (im2_reg >>> 2)));
    assign stat.escape = ((wext(zr2_reg) + wext(mq)) >= W_FOUR) || (n_reg >= max_iter_reg);

    // Capture the pixel and route each product to its register
    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            col_reg <= col;
            row_reg <= row;
        end
        unique case (ctrl.snk)
            SNK_NONE:  disk_reg <= disk_reg;
            SNK_CR:    cr_reg   <= sat_w(prod - W_RE_ORG);
            SNK_CI:    ci_reg   <= sat_w(prod - W_IM_ORG);
            SNK_RE2:   re2_reg  <= mq;
            SNK_IM2:
            begin
                im2_reg  <= mq;
                disk_reg <= (wext(re2_reg) + wext(mq)) < W_SIXTEENTH;
            end
            SNK_RP1:   disk_reg <= disk_reg | disk_hit;
            SNK_XX:    q_reg    <= sat_w(wext(mq) + wext(im2_reg));
            SNK_LHS:
            begin
                inside_reg <= stat.interior;
                zr_reg     <= '0;
                zi_reg     <= '0;
                n_reg      <= '0;
            end
            SNK_ZR2:   zr2_reg <= mq;
            SNK_ZI2:   zi2_reg <= mq;
            SNK_CROSS:
            begin
                zr_reg <= sat_w(wext(zr2_reg) - wext(zi2_reg) + wext(cr_reg));
                zi_reg <= sat_w((wext(mq) <<< 1) + wext(ci_reg));
                n_reg  <= n_reg + ITER_W'(1);
            end
            default:   disk_reg <= disk_reg;
        endcase
    end

    assign result = inside_reg ? max_iter_reg : n_reg;

endmodule

// ===== rtl/mandelbrot_escape_time_pixel.sv =====
// Top level of the escape-time pixel engine: sequencer, datapath, output register.
// Depends on mbrot_pkg, mbrot_fsm, mbrot_dp and the assertion macro header.
//
//  channel  dir  handshake         payload
//  s_*      in   tvalid / tready   tdata: col [11:0], row [23:12]
//  m_*      out  tvalid / tready   tdata: iterations [24:0], zeros above
//  cfg_*    in   cfg_we            cfg_index selects, cfg_data carries value
//
// One pixel at a time on a single 32x32 multiplier: the engine forms c and runs the
// disk and cardioid tests, then loops over orbit iterations (three products and an
// update each) until escape or the limit, and takes no new pixel until it is done.
// A point found inside skips the orbit loop. Reset needs no clearing pass.
// A finished result waits in the output register; the engine stalls only when
// a second result is ready before the first has been taken.
`include "mandelbrot_escape_time_pixel_defines.svh"

module mandelbrot_escape_time_pixel
    import mbrot_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // col [11:0], row [23:12]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // iterations [24:0]
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data
);

    ctrl_t             ctrl;
    stat_t             stat;
    logic [ITER_W-1:0] result;
    logic              out_free;
    logic              m_tvalid_reg;
    logic [ITER_W-1:0] iterations_reg;

    assign out_free = !m_tvalid_reg || m_tready;

    mbrot_fsm u_fsm (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .out_free (out_free),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    mbrot_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .col       (s_tdata[COORD_BITS-1:0]),
        .row       (s_tdata[2*COORD_BITS-1:COORD_BITS]),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .stat      (stat),
        .result    (result)
    );

    // Hold the result until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (ctrl.ld_out)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.ld_out)
            iterations_reg <= result;
    end

    assign s_tready = ctrl.ready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(OUT_DATA_W-ITER_W){1'b0}}, iterations_reg};

    // A new result never overwrites one still waiting
    `MBROT_ASSERT_IMP(a_no_overwrite, ctrl.ld_out, !m_tvalid_reg || m_tready)
    // The engine goes busy right after taking an item
    `MBROT_ASSERT_NXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
    // A loaded result is offered in the next cycle
    `MBROT_ASSERT_NXT(a_result_offered, ctrl.ld_out, m_tvalid)
    // Loading a result and taking an item never coincide
    `MBROT_ASSERT_IMP(a_load_excl_accept, ctrl.ld_out, !ctrl.accept)

endmodule

// ===== bench/mandelbrot_escape_time_pixel_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the escape-time pixel engine: drives pixel items, predicts
// each iteration count in fixed point, and checks every result item.
// Depends on mbrot_pkg and the mandelbrot_escape_time_pixel top level only.

module mandelbrot_escape_time_pixel_tb;
    import mbrot_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    localparam longint FX_ONE       = longint'(1) << FRAC_BITS;
    localparam longint FX_HI        = (longint'(1) << (Q_W - 1)) - 1;
    localparam longint FX_LO        = -(longint'(1) << (Q_W - 1));
    localparam longint FX_FOUR      = 4 * FX_ONE;
    localparam longint FX_SIXTEENTH = FX_ONE >>> 4;
    localparam longint FX_RE_ORG    = -2 * FX_ONE;
    localparam longint FX_IM_ORG    = -(9 * FX_ONE / 8);
    localparam longint RE_SPAN      = 3 * FX_ONE;
    localparam longint IM_SPAN      = 9 * FX_ONE / 4;

    // Orbit length above which a pixel is too slow to send under a large limit
    localparam longint QUICK_ITERS     = 300;
    localparam int     HOLD_CYCLES     = 400;
    localparam int     WATCHDOG_CYCLES = 10000;
    localparam int     TAIL_CYCLES     = 64;

    // Predicts iteration counts and holds the ones still owed by the block
    class escape_count_board;
        longint max_iter;
        longint step_re;
        longint step_im;
        longint pending_counts[$];
        int     errors;

        function new();
            max_iter = longint'(MAX_ITER_RST);
            step_re  = longint'(STEP_RE_RST);
            step_im  = longint'(STEP_IM_RST);
            errors   = 0;
        endfunction

        function void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
            case (idx)
                REG_MAX_ITER: max_iter = longint'(data[ITER_W-1:0]);
                REG_STEP_RE:  step_re  = longint'(data[STEP_W-1:0]);
                REG_STEP_IM:  step_im  = longint'(data[STEP_W-1:0]);
                default: ;
            endcase
        endfunction

        function longint fx_clamp(input longint v);
            if (v > FX_HI)
                return FX_HI;
            if (v < FX_LO)
                return FX_LO;
            return v;
        endfunction

        // Product floored to the fraction width, then clamped
        function longint fx_mul(input longint a, input longint b);
            longint p;
            p = a * b;
            return fx_clamp(p >>> FRAC_BITS);
        endfunction

        // Disk around 0, disk around -1, then the main cardioid
        function bit in_bulb_or_cardioid(input longint re, input longint im);
            longint im2;
            longint rp1;
            longint x;
            longint q;
            longint lhs;
            im2 = fx_mul(im, im);
            rp1 = re + FX_ONE;
            if (fx_mul(re, re) + im2 < FX_SIXTEENTH)
                return 1'b1;
            if (fx_mul(rp1, rp1) + im2 < FX_SIXTEENTH)
                return 1'b1;
            if (re > -(3 * FX_ONE / 4) && re < FX_ONE / 2)
            begin
                x   = re - FX_ONE / 4;
                q   = fx_clamp(fx_mul(x, x) + im2);
                lhs = fx_mul(q, fx_clamp(q + x));
                if (lhs < (im2 >>> 2))
                    return 1'b1;
            end
            return 1'b0;
        endfunction

        // Count for one pixel; flag slow when the orbit outlasts cap below the limit
        function longint escape_iters(input int col, input int row, input longint cap,
                                      output bit slow);
            longint cr;
            longint ci;
            longint zr;
            longint zi;
            longint zr2;
            longint zi2;
            longint zrzi;
            longint n;
            longint bound;
            slow = 1'b0;
            cr = fx_clamp(FX_RE_ORG + longint'(col) * step_re);
            ci = fx_clamp(FX_IM_ORG + longint'(row) * step_im);
            if (in_bulb_or_cardioid(cr, ci))
                return max_iter;
            bound = (cap < max_iter) ? cap : max_iter;
            zr = 0;
            zi = 0;
            n  = 0;
            while (1'b1)
            begin
                zr2 = fx_mul(zr, zr);
                zi2 = fx_mul(zi, zi);
                if (zr2 + zi2 >= FX_FOUR || n >= bound)
                    break;
                zrzi = fx_mul(zr, zi);
                zr = fx_clamp(zr2 - zi2 + cr);
                zi = fx_clamp(2 * zrzi + ci);
                n++;
            end
            slow = (n >= bound) && (bound < max_iter);
            return n;
        endfunction

        function void note_pixel(input int col, input int row);
            bit slow;
            pending_counts.push_back(escape_iters(col, row, max_iter, slow));
        endfunction

        function void check_count(input logic [OUT_DATA_W-1:0] data);
            longint want;
            if (pending_counts.size() == 0)
            begin
                $error("iterations: no item expected, got %0d", data[ITER_W-1:0]);
                errors++;
                return;
            end
            want = pending_counts.pop_front();
            if (longint'(data[ITER_W-1:0]) != want)
            begin
                $error("iterations: expected %0d, got %0d", want, data[ITER_W-1:0]);
                errors++;
            end
            if (data[OUT_DATA_W-1:ITER_W] != '0)
            begin
                $error("pad: expected 0, got 0x%0h", data[OUT_DATA_W-1:ITER_W]);
                errors++;
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;     // col [11:0], row [23:12]
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;          // iterations [24:0]
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_W-1:0]      cfg_data = '0;

    escape_count_board board;
    bit rx_burst = 1'b0;
    int rx_hold_cycles = 0;

    mandelbrot_escape_time_pixel i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Offer one pixel item after a random gap, or none in a burst, and hold it until accepted
    task automatic offer_pixel(input int col, input int row, input bit burst);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {row[COORD_BITS-1:0], col[COORD_BITS-1:0]};
        do @(posedge clk); while (!s_tready);
        board.note_pixel(col, row);
    endtask

    // Send a directed pixel unless its orbit would run too long
    task automatic offer_if_quick(input int col, input int row);
        bit slow;
        void'(board.escape_iters(col, row, QUICK_ITERS, slow));
        if (!slow)
            offer_pixel(col, row, 1'b0);
    endtask

    // Drop valid and wait until every owed count has come back
    task automatic wait_for_counts();
        s_tvalid <= 1'b0;
        while (board.pending_counts.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    task automatic program_regs(input logic [CFG_W-1:0] iter_limit,
                                input logic [CFG_W-1:0] re_step,
                                input logic [CFG_W-1:0] im_step,
                                input bit poke_unused);
        cfg_we    <= 1'b1;
        cfg_index <= REG_MAX_ITER;
        cfg_data  <= iter_limit;
        @(posedge clk);
        board.set_reg(REG_MAX_ITER, iter_limit);
        cfg_index <= REG_STEP_RE;
        cfg_data  <= re_step;
        @(posedge clk);
        board.set_reg(REG_STEP_RE, re_step);
        cfg_index <= REG_STEP_IM;
        cfg_data  <= im_step;
        @(posedge clk);
        board.set_reg(REG_STEP_IM, im_step);
        // An unmapped index must not disturb any register
        if (poke_unused)
        begin
            cfg_index <= REG_UNUSED;
            cfg_data  <= CFG_W'($urandom);
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    // One setting of the registers followed by random pixels
    task automatic run_phase(input logic [CFG_W-1:0] iter_limit,
                             input logic [CFG_W-1:0] re_step,
                             input logic [CFG_W-1:0] im_step,
                             input int col_hi, input int row_hi, input int items,
                             input bit poke_unused, input bit long_hold);
        int col;
        int row;
        bit slow;
        bit burst;
        wait_for_counts();
        program_regs(iter_limit, re_step, im_step, poke_unused);
        for (int i = 0; i < items; i++)
        begin
            burst = (i < items / 4) || (long_hold && i >= 20 && i < 32);
            rx_burst = (i < items / 4);
            if (long_hold && i == 20)
                rx_hold_cycles = HOLD_CYCLES;
            // Mostly inside the image window, sometimes anywhere in the field range
            do
            begin
                if ($urandom_range(0, 99) < 85)
                begin
                    col = $urandom_range(0, col_hi);
                    row = $urandom_range(0, row_hi);
                end
                else
                begin
                    col = $urandom_range(0, 4095);
                    row = $urandom_range(0, 4095);
                end
                void'(board.escape_iters(col, row, QUICK_ITERS, slow));
            end
            while (slow);
            offer_pixel(col, row, burst);
        end
        rx_burst = 1'b0;
    endtask

    // Result side: random stalls, one long hold-off on request
    initial
    begin
        int gap;
        wait (rst_n === 1'b1);
        forever
        begin
            gap = rx_burst ? 0 : $urandom_range(0, 15);
            if (rx_hold_cycles > 0)
            begin
                gap = rx_hold_cycles;
                rx_hold_cycles = 0;
            end
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            board.check_count(m_tdata);
        end
    end

    // End the run when nothing moves for too long
    initial
    begin
        int stall;
        stall = 0;
        wait (rst_n === 1'b1);
        while (stall < WATCHDOG_CYCLES)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
                stall = 0;
            else
                stall++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        board = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: field corners, both disks, the cardioid, quick escapes
        offer_if_quick(0, 0);
        offer_if_quick(4095, 4095);
        offer_if_quick(0, 4095);
        offer_if_quick(4095, 0);
        offer_if_quick(533, 300);
        offer_if_quick(266, 300);
        offer_if_quick(400, 433);
        offer_if_quick(700, 300);
        offer_if_quick(12'hAAA, 12'h555);
        offer_if_quick(12'h555, 12'hAAA);

        // Quarter and eighth steps land exactly on the cardioid window edges
        wait_for_counts();
        program_regs(CFG_W'(200), CFG_W'(FX_ONE / 4), CFG_W'(FX_ONE / 8), 1'b1);
        offer_if_quick(5, 9);
        offer_if_quick(10, 9);
        offer_if_quick(9, 9);
        offer_if_quick(8, 9);
        offer_if_quick(4, 9);
        offer_if_quick(3, 9);
        offer_if_quick(6, 13);
        offer_if_quick(7, 11);
        offer_if_quick(0, 0);
        offer_if_quick(4095, 4095);
        offer_if_quick(4095, 0);
        offer_if_quick(0, 4095);

        run_phase(CFG_W'(32), CFG_W'(RE_SPAN / 63), CFG_W'(IM_SPAN / 47),
                  63, 47, 180, 1'b0, 1'b0);
        run_phase(CFG_W'(100), CFG_W'(STEP_RE_RST), CFG_W'(STEP_IM_RST),
                  799, 599, 180, 1'b0, 1'b1);
        run_phase(CFG_W'(0), CFG_W'($urandom), CFG_W'($urandom),
                  4095, 4095, 30, 1'b0, 1'b0);
        run_phase(CFG_W'(1), CFG_W'(RE_SPAN / 199), CFG_W'(IM_SPAN / 149),
                  199, 149, 40, 1'b1, 1'b0);
        run_phase(CFG_W'(255), CFG_W'(RE_SPAN / 199), CFG_W'(IM_SPAN / 149),
                  199, 149, 180, 1'b0, 1'b0);
        // All-ones write also sets bits above the limit field
        run_phase({CFG_W{1'b1}}, CFG_W'(RE_SPAN / 4095), CFG_W'(IM_SPAN / 4095),
                  4095, 4095, 100, 1'b0, 1'b0);
        run_phase(CFG_W'(16777216), '0, {CFG_W{1'b1}}, 4095, 4095, 50, 1'b0, 1'b0);
        run_phase(CFG_W'(50), {CFG_W{1'b1}}, '0, 4095, 4095, 50, 1'b0, 1'b0);
        run_phase(CFG_W'(20), CFG_W'(RE_SPAN), CFG_W'(IM_SPAN), 4095, 4095, 60, 1'b0, 1'b0);
        run_phase(CFG_W'(64), CFG_W'(STEP_RE_RST), CFG_W'(STEP_IM_RST),
                  799, 599, 150, 1'b1, 1'b0);

        wait_for_counts();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (board.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
